@@ sv/ntscd_pkg.sv @@
// ============================================================================
// ntscd_pkg: shared constants and helpers for the composite comb decoder
// Holds the voltage and subcarrier tables, the fixed-point scaling constants,
// and the small functions that build a composite level and finish a quotient.
// ============================================================================
`default_nettype none

package ntscd_pkg;

    // Fixed-point format of all three results.
    localparam int FRACTION_BITS = 14;

    // Field widths.
    localparam int PIX_W   = 9;
    localparam int PHASE_W = 4;
    localparam int GAIN_W  = 16;
    localparam int Q_W     = 16;

    // Subcarrier period in samples.
    localparam int PHASES = 12;

    // Reset value of the chroma gain register (1.4 in unsigned Q2.14).
    localparam logic [GAIN_W-1:0] CHROMA_GAIN_RST = 16'd22938;

    // Special colors.
    localparam logic [3:0] COLOR_BLACK    = 4'h0;
    localparam logic [3:0] COLOR_LAST_HUE = 4'hC;
    localparam logic [3:0] COLOR_GRAY_LO  = 4'hD;
    localparam logic [3:0] COLOR_FORCE_L1 = 4'hE;

    // Level numerator in millionths: volt_mv * scale - black level.
    localparam int SCALE_FULL = 1000;
    localparam int SCALE_EMPH = 746;
    localparam int BLACK_NUM  = 518000;

    localparam int LEVEL_FULL [8] = '{
        350 * SCALE_FULL - BLACK_NUM,  518 * SCALE_FULL - BLACK_NUM,
        962 * SCALE_FULL - BLACK_NUM,  1550 * SCALE_FULL - BLACK_NUM,
        1094 * SCALE_FULL - BLACK_NUM, 1506 * SCALE_FULL - BLACK_NUM,
        1962 * SCALE_FULL - BLACK_NUM, 1962 * SCALE_FULL - BLACK_NUM
    };
    localparam int LEVEL_EMPH [8] = '{
        350 * SCALE_EMPH - BLACK_NUM,  518 * SCALE_EMPH - BLACK_NUM,
        962 * SCALE_EMPH - BLACK_NUM,  1550 * SCALE_EMPH - BLACK_NUM,
        1094 * SCALE_EMPH - BLACK_NUM, 1506 * SCALE_EMPH - BLACK_NUM,
        1962 * SCALE_EMPH - BLACK_NUM, 1962 * SCALE_EMPH - BLACK_NUM
    };

    // Datapath widths.
    localparam int LVL_W   = 22;                 // one level numerator
    localparam int SUM_W   = LVL_W + 1;          // field sum and difference
    localparam int TRIG_W  = 17;                 // signed Q1.16 cos/sin
    localparam int GD_W    = GAIN_W + 1 + SUM_W; // gain times difference
    localparam int PROD_W  = GD_W + TRIG_W;      // demodulator product
    localparam int WIDE_W  = 64;

    // Both divisions reduce to a rounding shift and a division by DIV_BASE.
    // Full-scale span 2888000 = DIV_BASE * 2^6.
    localparam longint DIV_BASE     = 45125;
    localparam int     LUMA_SHIFT   = FRACTION_BITS - 6;
    localparam longint LUMA_BIAS    = (DIV_BASE * 32) / 64;
    localparam int     CHROMA_SHIFT = 36 - FRACTION_BITS;
    localparam longint CHROMA_HALF  = DIV_BASE << (CHROMA_SHIFT - 1);

    // Any quotient of 32768 or more saturates, so dividends clamp here.
    localparam longint X_MAX    = 32768 * DIV_BASE;
    localparam int     X_W      = 31;
    localparam int     RECIP_SHIFT = 46;
    localparam int     RECIP_W  = 31;
    localparam longint RECIP    = (64'sd1 <<< RECIP_SHIFT) / DIV_BASE;
    localparam int     RP_W     = X_W + RECIP_W;

    // Number of register stages from input to result.
    localparam int PIPE_DEPTH = 7;

    // Magnitude and sign of a value on its way through the divider.
    typedef struct packed {
        logic           neg;
        logic [X_W-1:0] mag;
    } t_div_op;

    function automatic logic [4:0] mod12(input logic [4:0] v);
        if (v >= 5'(2 * PHASES)) begin
            return v - 5'(2 * PHASES);
        end else if (v >= 5'(PHASES)) begin
            return v - 5'(PHASES);
        end
        return v;
    endfunction

    // Composite level numerator of one pixel at one subcarrier phase (0..11).
    function automatic logic signed [LVL_W-1:0] level_num(
        input logic [PIX_W-1:0]   pix,
        input logic [PHASE_W-1:0] ph
    );
        logic [3:0] color;
        logic [1:0] lvl;
        logic [2:0] emph;
        logic       hi_phase;
        logic       use_hi;
        logic       att;
        logic [2:0] vidx;
        color    = pix[3:0];
        lvl      = (color >= COLOR_FORCE_L1) ? 2'd1 : pix[5:4];
        emph     = pix[8:6];
        hi_phase = mod12({1'b0, color} + {1'b0, ph}) < 5'd6;
        att = (color < COLOR_FORCE_L1) &&
              ((emph[0] && ({1'b0, ph} < 5'd6)) ||
               (emph[1] && (mod12(5'd4 + {1'b0, ph}) < 5'd6)) ||
               (emph[2] && (mod12(5'd8 + {1'b0, ph}) < 5'd6)));
        if (color == COLOR_BLACK) begin
            use_hi = 1'b1;
        end else if (color >= COLOR_GRAY_LO) begin
            use_hi = 1'b0;
        end else begin
            use_hi = hi_phase;
        end
        vidx = {use_hi, lvl};
        return att ? LVL_W'(LEVEL_EMPH[vidx]) : LVL_W'(LEVEL_FULL[vidx]);
    endfunction

    // Demodulator tables: cos and sin of (p*30 + 147) degrees in Q1.16.
    function automatic logic signed [TRIG_W-1:0] cos_q16(input logic [PHASE_W-1:0] ph);
        unique case (ph)
            4'd0:    return TRIG_W'(-54963);
            4'd1:    return TRIG_W'(-65446);
            4'd2:    return TRIG_W'(-58393);
            4'd3:    return TRIG_W'(-35693);
            4'd4:    return TRIG_W'(-3430);
            4'd5:    return TRIG_W'(29753);
            4'd6:    return TRIG_W'(54963);
            4'd7:    return TRIG_W'(65446);
            4'd8:    return TRIG_W'(58393);
            4'd9:    return TRIG_W'(35693);
            4'd10:   return TRIG_W'(3430);
            4'd11:   return TRIG_W'(-29753);
            default: return '0;
        endcase
    endfunction

    function automatic logic signed [TRIG_W-1:0] sin_q16(input logic [PHASE_W-1:0] ph);
        unique case (ph)
            4'd0:    return TRIG_W'(35693);
            4'd1:    return TRIG_W'(3430);
            4'd2:    return TRIG_W'(-29753);
            4'd3:    return TRIG_W'(-54963);
            4'd4:    return TRIG_W'(-65446);
            4'd5:    return TRIG_W'(-58393);
            4'd6:    return TRIG_W'(-35693);
            4'd7:    return TRIG_W'(-3430);
            4'd8:    return TRIG_W'(29753);
            4'd9:    return TRIG_W'(54963);
            4'd10:   return TRIG_W'(65446);
            4'd11:   return TRIG_W'(58393);
            default: return '0;
        endcase
    endfunction

    function automatic logic [X_W-1:0] clamp_x(input logic [WIDE_W-1:0] v);
        if (v > WIDE_W'(X_MAX)) begin
            return X_W'(X_MAX);
        end
        return v[X_W-1:0];
    endfunction

    // Quotient estimate by reciprocal; low by at most one.
    function automatic logic [Q_W-1:0] quot_est(input logic [X_W-1:0] x);
        logic [RP_W-1:0] p;
        p = RP_W'(x) * RP_W'(RECIP);
        return p[RECIP_SHIFT +: Q_W];
    endfunction

    function automatic logic [Q_W-1:0] quot_fix(
        input logic [X_W-1:0] x,
        input logic [Q_W-1:0] qe
    );
        logic [X_W-1:0] prod;
        logic [X_W-1:0] rem;
        prod = X_W'(qe) * X_W'(DIV_BASE);
        rem  = x - prod;
        return qe + Q_W'(rem >= X_W'(DIV_BASE));
    endfunction

    // Apply the sign; only the positive side can exceed the range.
    function automatic logic signed [Q_W-1:0] sat_q(
        input logic           neg,
        input logic [Q_W-1:0] q
    );
        if (!neg && q[Q_W-1]) begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
        return neg ? -q : q;
    endfunction

endpackage

`default_nettype wire

@@ sv/ntscd_if.sv @@
// ============================================================================
// ntscd interfaces: pixel request and result channels
// Valid/ready channels carrying one pixel sample in and one decoded result out.
// ============================================================================
`default_nettype none

interface ntscd_in_if;
    logic                              valid;
    logic                              ready;
    logic [ntscd_pkg::PIX_W-1:0]       pixel_code;
    logic [ntscd_pkg::PHASE_W-1:0]     sample_phase;

    modport source (output valid, output pixel_code, output sample_phase, input ready);
    modport sink   (input valid, input pixel_code, input sample_phase, output ready);
endinterface

interface ntscd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ntscd_pkg::Q_W-1:0]  luma;
    logic signed [ntscd_pkg::Q_W-1:0]  inphase;
    logic signed [ntscd_pkg::Q_W-1:0]  quadrature;

    modport source (output valid, output luma, output inphase, output quadrature, input ready);
    modport sink   (input valid, input luma, input inphase, input quadrature, output ready);
endinterface

`default_nettype wire

@@ sv/ntsc_composite_signal_comb_decode.sv @@
// ============================================================================
// ntsc_composite_signal_comb_decode: composite sample comb decoder
// Builds the composite level of a palette pixel on two fields, comb-separates
// luma and chroma, and demodulates chroma into I and Q.
// ============================================================================
// Usage
// Requests arrive on i_pix (pixel_code, sample_phase) and are taken at any
// clock edge where valid and ready are both high. Each request produces one
// result on o_res (luma, inphase, quadrature, all signed Q2.14, saturated).
// The datapath is a seven-register pipeline: input register, level/comb stage,
// gain multiply, demodulator multiply, rounding shift, reciprocal multiply and
// the quotient correction that loads the result register. One request is taken
// in every cycle while the receiver keeps up; the two multipliers in series
// with the reciprocal multiply set the stage count.
// Each stage holds its own valid bit. When the receiver holds o_res.ready low,
// the result register keeps its value and the stages behind it keep filling
// until every stage is occupied; only then does i_pix.ready drop.
// The chroma gain register is written through i_cfg_wr_en/i_cfg_wr_data and
// should only change while no request is in flight. Synchronous reset empties
// the pipeline and loads the gain with 1.4.
// ============================================================================
`default_nettype none

module ntsc_composite_signal_comb_decode (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [ntscd_pkg::GAIN_W-1:0]   i_cfg_wr_data,
    ntscd_in_if.sink                            i_pix,
    ntscd_out_if.source                         o_res
);

    localparam int NST = ntscd_pkg::PIPE_DEPTH;

    // Handshake chain: a stage may load when it is empty or its content moves on.
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_rdy;

    always_comb begin
        w_rdy[NST-1] = !r_vld[NST-1] || o_res.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Chroma gain register.
    logic [ntscd_pkg::GAIN_W-1:0] r_chroma_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma_gain <= ntscd_pkg::CHROMA_GAIN_RST;
        end else if (i_cfg_wr_en) begin
            r_chroma_gain <= i_cfg_wr_data;
        end
    end

    // Stage 0: input register. Phases twelve and above wrap to the period.
    logic [ntscd_pkg::PIX_W-1:0]   r_pix;
    logic [ntscd_pkg::PHASE_W-1:0] r_ph0;
    logic [ntscd_pkg::PHASE_W-1:0] n_ph0;

    assign n_ph0 = (i_pix.sample_phase >= ntscd_pkg::PHASE_W'(ntscd_pkg::PHASES))
                 ? i_pix.sample_phase - ntscd_pkg::PHASE_W'(ntscd_pkg::PHASES)
                 : i_pix.sample_phase;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_pix.valid) begin
            r_pix <= i_pix.pixel_code;
            r_ph0 <= n_ph0;
        end
    end

    // Stage 1: level of both fields, the second one eight samples later,
    // then the comb sum and difference.
    logic [ntscd_pkg::PHASE_W-1:0]       w_ph8;
    logic signed [ntscd_pkg::LVL_W-1:0]  n_lvl0;
    logic signed [ntscd_pkg::LVL_W-1:0]  n_lvl1;
    logic signed [ntscd_pkg::SUM_W-1:0]  n_sum;
    logic signed [ntscd_pkg::SUM_W-1:0]  n_diff;
    logic signed [ntscd_pkg::SUM_W-1:0]  r_sum;
    logic signed [ntscd_pkg::SUM_W-1:0]  r_diff;
    logic [ntscd_pkg::PHASE_W-1:0]       r_ph1;

    assign w_ph8  = ntscd_pkg::PHASE_W'(ntscd_pkg::mod12(5'(r_ph0) + 5'd8));
    assign n_lvl0 = ntscd_pkg::level_num(r_pix, r_ph0);
    assign n_lvl1 = ntscd_pkg::level_num(r_pix, w_ph8);
    assign n_sum  = n_lvl0 + n_lvl1;
    assign n_diff = n_lvl0 - n_lvl1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[1] && r_vld[0]) begin
            r_sum  <= n_sum;
            r_diff <= n_diff;
            r_ph1  <= r_ph0;
        end
    end

    // Stage 2: luma rounding offset and magnitude; chroma gain multiply and
    // the demodulator table lookup.
    logic [ntscd_pkg::SUM_W-1:0]          w_sum_mag;
    ntscd_pkg::t_div_op                   n_luma_op;
    logic signed [ntscd_pkg::GAIN_W:0]    w_gain_s;
    logic signed [ntscd_pkg::GD_W-1:0]    n_gd;
    ntscd_pkg::t_div_op                   r_luma_op2;
    logic signed [ntscd_pkg::GD_W-1:0]    r_gd;
    logic signed [ntscd_pkg::TRIG_W-1:0]  r_cos;
    logic signed [ntscd_pkg::TRIG_W-1:0]  r_sin;

    assign w_sum_mag     = r_sum[ntscd_pkg::SUM_W-1] ? -r_sum : r_sum;
    assign n_luma_op.neg = r_sum[ntscd_pkg::SUM_W-1];
    assign n_luma_op.mag = ntscd_pkg::clamp_x(
        (ntscd_pkg::WIDE_W'(w_sum_mag) << ntscd_pkg::LUMA_SHIFT)
        + ntscd_pkg::WIDE_W'(ntscd_pkg::LUMA_BIAS));
    assign w_gain_s      = $signed({1'b0, r_chroma_gain});
    assign n_gd          = w_gain_s * r_diff;

    always_ff @(posedge i_clk) begin
        if (w_rdy[2] && r_vld[1]) begin
            r_luma_op2 <= n_luma_op;
            r_gd       <= n_gd;
            r_cos      <= ntscd_pkg::cos_q16(r_ph1);
            r_sin      <= ntscd_pkg::sin_q16(r_ph1);
        end
    end

    // Stage 3: demodulator multiplies.
    logic signed [ntscd_pkg::PROD_W-1:0] n_pi;
    logic signed [ntscd_pkg::PROD_W-1:0] n_pq;
    logic signed [ntscd_pkg::PROD_W-1:0] r_pi;
    logic signed [ntscd_pkg::PROD_W-1:0] r_pq;
    ntscd_pkg::t_div_op                  r_luma_op3;

    assign n_pi = r_gd * r_cos;
    assign n_pq = r_gd * r_sin;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3] && r_vld[2]) begin
            r_pi       <= n_pi;
            r_pq       <= n_pq;
            r_luma_op3 <= r_luma_op2;
        end
    end

    // Stage 4: rounding shift of the chroma products; from here on the three
    // channels share one form, a magnitude divided by the common base.
    // Lane 0 is luma, lane 1 is I, lane 2 is Q.
    logic [ntscd_pkg::PROD_W-1:0] w_pi_mag;
    logic [ntscd_pkg::PROD_W-1:0] w_pq_mag;
    ntscd_pkg::t_div_op           n_op4 [3];
    ntscd_pkg::t_div_op           r_op4 [3];

    assign w_pi_mag = r_pi[ntscd_pkg::PROD_W-1] ? -r_pi : r_pi;
    assign w_pq_mag = r_pq[ntscd_pkg::PROD_W-1] ? -r_pq : r_pq;

    always_comb begin
        n_op4[0]     = r_luma_op3;
        n_op4[1].neg = r_pi[ntscd_pkg::PROD_W-1];
        n_op4[1].mag = ntscd_pkg::clamp_x(
            (ntscd_pkg::WIDE_W'(w_pi_mag) + ntscd_pkg::WIDE_W'(ntscd_pkg::CHROMA_HALF))
            >> ntscd_pkg::CHROMA_SHIFT);
        n_op4[2].neg = r_pq[ntscd_pkg::PROD_W-1];
        n_op4[2].mag = ntscd_pkg::clamp_x(
            (ntscd_pkg::WIDE_W'(w_pq_mag) + ntscd_pkg::WIDE_W'(ntscd_pkg::CHROMA_HALF))
            >> ntscd_pkg::CHROMA_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[4] && r_vld[3]) begin
            r_op4 <= n_op4;
        end
    end

    // Stage 5: reciprocal multiply gives a quotient that may be one short.
    ntscd_pkg::t_div_op          r_op5 [3];
    logic [ntscd_pkg::Q_W-1:0]   r_qe  [3];

    always_ff @(posedge i_clk) begin
        if (w_rdy[5] && r_vld[4]) begin
            for (int k = 0; k < 3; k++) begin
                r_op5[k] <= r_op4[k];
                r_qe[k]  <= ntscd_pkg::quot_est(r_op4[k].mag);
            end
        end
    end

    // Stage 6: remainder check, sign and saturation into the result register.
    logic signed [ntscd_pkg::Q_W-1:0] n_res [3];
    logic signed [ntscd_pkg::Q_W-1:0] r_res [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_res[k] = ntscd_pkg::sat_q(r_op5[k].neg,
                                        ntscd_pkg::quot_fix(r_op5[k].mag, r_qe[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[6] && r_vld[5]) begin
            r_res <= n_res;
        end
    end

    assign i_pix.ready      = w_rdy[0];
    assign o_res.valid      = r_vld[NST-1];
    assign o_res.luma       = r_res[0];
    assign o_res.inphase    = r_res[1];
    assign o_res.quadrature = r_res[2];

endmodule

`default_nettype wire

@@ sv/ntscd_checker.sv @@
// ============================================================================
// ntscd_checker: port-level checks for the composite comb decoder
// Tracks requests in flight from the handshakes and checks their number
// against the pipeline depth, along with result hold and input ready.
// ============================================================================
`default_nettype none

module ntscd_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [3*ntscd_pkg::Q_W-1:0] i_out_data
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign n_cnt     = r_cnt + 4'(w_in_acc) - 4'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // Never more requests in flight than pipeline stages.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'(ntscd_pkg::PIPE_DEPTH))
        else $error("more requests in flight than pipeline stages");

    // No result without a pending request.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 4'd0 |-> !i_out_valid)
        else $error("result shown with no request in flight");

    // An empty result register never blocks the input.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while the result register is empty");

endmodule

bind ntsc_composite_signal_comb_decode ntscd_checker u_ntscd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.luma, o_res.inphase, o_res.quadrature})
);

`default_nettype wire

@@ bench/tb_ntsc_composite_signal_comb_decode.sv @@
// ============================================================================
// tb_ntsc_composite_signal_comb_decode: self-checking bench for the comb decoder
// Drives pixel requests through the valid/ready channels with random gaps,
// predicts luma, I and Q for every accepted request with an independent
// fixed-point model, and compares each result in arrival order. The chroma
// gain register is swept through several settings, the extremes among them.
// ============================================================================
`default_nettype none

module tb_ntsc_composite_signal_comb_decode;

    localparam int F_BITS       = ntscd_pkg::FRACTION_BITS;
    localparam int CYCLE_LIMIT  = 200000;
    // Spare cycles after the last result let the pipeline drain fully before
    // a gain write or the final verdict.
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 100;
    localparam int HOLD_AT      = 150;
    localparam int PHASE_ITEMS  = 80;

    // Composite voltages in millivolts: four low levels, then four high levels.
    localparam int VOLT_MV [8] = '{350, 518, 962, 1550, 1094, 1506, 1962, 1962};

    // Demodulator tables, cos and sin of (p * 30 + 147) degrees in Q1.16.
    localparam int COS_Q16 [12] = '{
        -54963, -65446, -58393, -35693, -3430, 29753,
        54963, 65446, 58393, 35693, 3430, -29753
    };
    localparam int SIN_Q16 [12] = '{
        35693, 3430, -29753, -54963, -65446, -58393,
        -35693, -3430, 29753, 54963, 65446, 58393
    };

    localparam longint BLACK_UV    = 518000;  // black level in millionths
    localparam longint SPAN_UV     = 2888000; // twice the black-to-white span
    localparam int     FULL_SCALE  = 1000;
    localparam int     EMPH_SCALE  = 746;

    typedef struct {
        logic signed [15:0] luma;
        logic signed [15:0] inphase;
        logic signed [15:0] quadrature;
    } decoded_sample_t;

    // ------------------------------------------------------------------------
    // Decoded-sample scoreboard. It keeps its own copy of the chroma gain and
    // turns every accepted pixel request into the luma/I/Q it must produce.
    // ------------------------------------------------------------------------
    class comb_scoreboard;
        logic [15:0]     chroma_gain;
        decoded_sample_t expected_samples[$];
        int              error_count;

        function new();
            chroma_gain = ntscd_pkg::CHROMA_GAIN_RST;
            error_count = 0;
        endfunction

        // Composite level of one field in millionths, relative to black.
        function longint field_level(logic [8:0] pix, int ph);
            logic [3:0] color;
            logic [2:0] emph;
            int         lvl;
            longint     lo_mv;
            longint     hi_mv;
            longint     volts;
            bit         damped;
            color = pix[3:0];
            emph  = pix[8:6];
            lvl   = int'(pix[5:4]);
            if (color >= ntscd_pkg::COLOR_FORCE_L1) lvl = 1;
            lo_mv = VOLT_MV[lvl];
            hi_mv = VOLT_MV[lvl + 4];
            if (color == ntscd_pkg::COLOR_BLACK) lo_mv = hi_mv;
            if (color >= ntscd_pkg::COLOR_GRAY_LO) hi_mv = lo_mv;
            volts  = ((int'(color) + ph) % 12 < 6) ? hi_mv : lo_mv;
            damped = (color < ntscd_pkg::COLOR_FORCE_L1) &&
                     ((emph[0] && (ph % 12 < 6)) ||
                      (emph[1] && ((4 + ph) % 12 < 6)) ||
                      (emph[2] && ((8 + ph) % 12 < 6)));
            return volts * (damped ? EMPH_SCALE : FULL_SCALE) - BLACK_UV;
        endfunction

        // Division rounded to nearest, ties away from zero, then clamped.
        function logic signed [15:0] round_clamp(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q   = (mag + den / 2) / den;
            if (num < 0) q = -q;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return 16'(q);
        endfunction

        function void note_request(logic [8:0] pix, logic [3:0] phase_in);
            decoded_sample_t s;
            int     ph;
            longint lvl_a;
            longint lvl_b;
            longint gain_diff;
            longint chroma_den;
            ph         = int'(phase_in) % 12;
            lvl_a      = field_level(pix, ph);
            lvl_b      = field_level(pix, (ph + 8) % 12);
            gain_diff  = longint'(chroma_gain) * (lvl_a - lvl_b);
            chroma_den = SPAN_UV <<< (30 - F_BITS);
            s.luma       = round_clamp((lvl_a + lvl_b) <<< F_BITS, SPAN_UV);
            s.inphase    = round_clamp(gain_diff * COS_Q16[ph], chroma_den);
            s.quadrature = round_clamp(gain_diff * SIN_Q16[ph], chroma_den);
            expected_samples.push_back(s);
        endfunction

        function void check_result(logic signed [15:0] luma, logic signed [15:0] inphase,
                                   logic signed [15:0] quadrature);
            decoded_sample_t s;
            if (expected_samples.size() == 0) begin
                $error("result with no request outstanding: luma %0d I %0d Q %0d",
                       luma, inphase, quadrature);
                error_count++;
                return;
            end
            s = expected_samples.pop_front();
            if (luma !== s.luma) begin
                $error("luma: expected %0d, actual %0d", s.luma, luma);
                error_count++;
            end
            if (inphase !== s.inphase) begin
                $error("inphase: expected %0d, actual %0d", s.inphase, inphase);
                error_count++;
            end
            if (quadrature !== s.quadrature) begin
                $error("quadrature: expected %0d, actual %0d", s.quadrature, quadrature);
                error_count++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    ntscd_in_if  pix_if ();
    ntscd_out_if res_if ();

    ntsc_composite_signal_comb_decode u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pix         (pix_if),
        .o_res         (res_if)
    );

    comb_scoreboard sb = new();

    int cycle_count  = 0;
    int results_seen = 0;

    // Gap state for each side: a run of items either idles at random or not
    // at all, so the bench sees both bursty and back-to-back traffic.
    int send_run_left = 0;
    bit send_calm     = 1'b0;
    int recv_run_left = 0;
    bit recv_calm     = 1'b0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watchdog. The slowest legal run is far below this limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ntsc_composite_signal_comb_decode regression: fail");
            $finish;
        end
    end

    // Draws the wait before the next handshake, none during a calm run.
    function automatic int draw_gap(ref int run_left, ref bit calm);
        if (run_left == 0) begin
            run_left = $urandom_range(10, 40);
            calm     = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return calm ? 0 : $urandom_range(0, 8);
    endfunction

    // Offers one pixel request and waits until the decoder takes it. Valid is
    // left high after the handshake; it drops only when a gap follows, so it
    // is never lowered and raised within one time step.
    task automatic send_pixel(input logic [8:0] pix, input logic [3:0] phase_in);
        int gap;
        gap = draw_gap(send_run_left, send_calm);
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid        <= 1'b1;
        pix_if.pixel_code   <= pix;
        pix_if.sample_phase <= phase_in;
        do @(posedge i_clk); while (!pix_if.ready);
        sb.note_request(pix, phase_in);
    endtask

    // Lets the pipeline run dry, then writes the chroma gain while idle.
    task automatic write_gain(input logic [15:0] value);
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        sb.chroma_gain = value;
    endtask

    // Random pixel code and phase. Phases twelve to fifteen appear now and
    // then, so the wrap of the phase is exercised throughout.
    task automatic send_random_pixels(input int count);
        logic [3:0] ph;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                ph = 4'($urandom_range(12, 15));
            end else begin
                ph = 4'($urandom_range(0, 11));
            end
            send_pixel(9'($urandom_range(0, 511)), ph);
        end
    endtask

    // Result side. It takes results with random gaps and, once during the
    // run, holds ready low for a long stretch so that the pipeline fills and
    // the decoder has to stall its input.
    task automatic take_results();
        int  gap;
        bit  held;
        held = 1'b0;
        forever begin
            gap = draw_gap(recv_run_left, recv_calm);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            sb.check_result(res_if.luma, res_if.inphase, res_if.quadrature);
            results_seen++;
        end
    endtask

    initial begin
        logic [8:0] pix;
        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_wr_data       <= '0;
        pix_if.valid        <= 1'b0;
        pix_if.pixel_code   <= '0;
        pix_if.sample_phase <= '0;
        res_if.ready        <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fork
            take_results();
        join_none

        // Directed part at the reset gain. Every color once, with the level
        // and emphasis varied across them, so black, the gray colors and the
        // two colors that ignore level and emphasis are all covered.
        for (int c = 0; c < 16; c++) begin
            pix = {3'(c % 8), 2'(c % 4), 4'(c)};
            send_pixel(pix, 4'(c % 12));
        end
        // Field extremes, and phases above eleven that must wrap.
        send_pixel(9'h000, 4'd0);
        send_pixel(9'h1FF, 4'd15);
        send_pixel(9'h1C1, 4'd11);
        send_pixel(9'h1F2, 4'd12);
        send_pixel(9'h0BD, 4'd13);
        send_pixel(9'h17E, 4'd14);
        send_pixel(9'h130, 4'd5);
        send_pixel(9'h03C, 4'd6);
        send_random_pixels(PHASE_ITEMS);

        // Full-scale gain gives the largest I and Q magnitudes.
        write_gain(16'hFFFF);
        send_pixel(9'h1C1, 4'd3);
        send_pixel(9'h031, 4'd14);
        send_random_pixels(PHASE_ITEMS);

        // Zero gain removes chroma entirely.
        write_gain(16'h0000);
        send_random_pixels(PHASE_ITEMS);

        write_gain(16'($urandom_range(0, 65535)));
        send_random_pixels(PHASE_ITEMS);

        write_gain(16'h0001);
        send_random_pixels(PHASE_ITEMS / 2);

        write_gain(ntscd_pkg::CHROMA_GAIN_RST);
        send_random_pixels(PHASE_ITEMS / 2);

        // Wait for every outstanding result, then a few cycles for strays.
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.error_count == 0) begin
            $display("ntsc_composite_signal_comb_decode regression: pass");
        end else begin
            $display("ntsc_composite_signal_comb_decode regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
sv/ntscd_pkg.sv
sv/ntscd_if.sv
sv/ntsc_composite_signal_comb_decode.sv
sv/ntscd_checker.sv
bench/tb_ntsc_composite_signal_comb_decode.sv
